// ===== rtl/core/c2bd_pkg.sv =====
// c2bd_pkg: widths, constants, payload types and the arctangent table
// for the cartesian-to-bearing/distance core. No dependencies.
`timescale 1ns / 1ps

package c2bd_pkg;

  localparam int unsigned COORD_W     = 16;
  localparam int unsigned DIFF_W      = COORD_W + 1;
  localparam int unsigned DIST_W      = 17;
  localparam int unsigned BEAR_W      = 15;
  localparam int unsigned GUARD_SHIFT = 8;
  localparam int unsigned UV_W        = 28;   // |u|,|v| stay below 2^26 with CORDIC gain
  localparam int unsigned Z_W         = 28;   // angle in 2^-18 degree
  localparam int unsigned ATAN_LEN    = 24;
  localparam int unsigned ATAN_IDX_W  = 5;
  localparam int unsigned KINV_W      = 32;
  localparam int unsigned PROD_W      = UV_W - 1 + KINV_W;
  localparam int unsigned T_W         = Z_W + 1;
  localparam int unsigned BQ_W        = T_W - 12;

  localparam logic [KINV_W-1:0]     KINV_Q32  = 32'd2608131496;
  localparam logic signed [Z_W-1:0] Z_180     = 28'sd47185920;
  localparam logic signed [T_W-1:0] Z_OFFSET  = 29'sd94373888;  // 360 deg + half lsb
  localparam logic [BQ_W-1:0]       BEAR_FULL = 17'd23040;
  localparam logic [BEAR_W-1:0]     BEAR_0    = 15'd0;
  localparam logic [BEAR_W-1:0]     BEAR_90   = 15'd5760;
  localparam logic [BEAR_W-1:0]     BEAR_180  = 15'd11520;
  localparam logic [BEAR_W-1:0]     BEAR_270  = 15'd17280;

  typedef struct packed {
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic signed [COORD_W-1:0] current_x;
    logic signed [COORD_W-1:0] current_y;
  } c2bd_pt_t;

  // State handed from cell to cell, with the axis-case result riding along.
  typedef struct packed {
    logic signed [UV_W-1:0] u;
    logic signed [UV_W-1:0] v;
    logic signed [Z_W-1:0]  z;
    logic                   sp;
    logic [DIST_W-1:0]      sp_dist;
    logic [BEAR_W-1:0]      sp_bear;
  } c2bd_vec_t;

  // atan(2^-i) in 2^-18 degree, rounded to nearest
  function automatic logic signed [Z_W-1:0] atan_lookup(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [Z_W-1:0] r;
    case (idx)
      5'd0:    r = 28'sd11796480;
      5'd1:    r = 28'sd6963869;
      5'd2:    r = 28'sd3679517;
      5'd3:    r = 28'sd1867780;
      5'd4:    r = 28'sd937515;
      5'd5:    r = 28'sd469214;
      5'd6:    r = 28'sd234664;
      5'd7:    r = 28'sd117339;
      5'd8:    r = 28'sd58671;
      5'd9:    r = 28'sd29335;
      5'd10:   r = 28'sd14668;
      5'd11:   r = 28'sd7334;
      5'd12:   r = 28'sd3667;
      5'd13:   r = 28'sd1833;
      5'd14:   r = 28'sd917;
      5'd15:   r = 28'sd458;
      5'd16:   r = 28'sd229;
      5'd17:   r = 28'sd115;
      5'd18:   r = 28'sd57;
      5'd19:   r = 28'sd29;
      5'd20:   r = 28'sd14;
      5'd21:   r = 28'sd7;
      5'd22:   r = 28'sd4;
      5'd23:   r = 28'sd2;
      default: r = 28'sd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/c2bd_req_if.sv =====
// c2bd_req_if: request channel carrying the target and current points.
// Depends on c2bd_pkg.
`timescale 1ns / 1ps

interface c2bd_req_if import c2bd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] target_x;
  logic signed [COORD_W-1:0] target_y;
  logic signed [COORD_W-1:0] current_x;
  logic signed [COORD_W-1:0] current_y;

  modport source (output valid, target_x, target_y, current_x, current_y, input ready);
  modport sink   (input valid, target_x, target_y, current_x, current_y, output ready);
endinterface

// ===== rtl/core/c2bd_rsp_if.sv =====
// c2bd_rsp_if: result channel carrying distance and bearing.
// Depends on c2bd_pkg.
`timescale 1ns / 1ps

interface c2bd_rsp_if import c2bd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  logic [BEAR_W-1:0] bearing;

  modport source (output valid, distance, bearing, input ready);
  modport sink   (input valid, distance, bearing, output ready);
endinterface

// ===== rtl/core/cartesian_to_bearing_distance_core.sv =====
// cartesian_to_bearing_distance_core: top level, a row of CORDIC cells
// between a front stage and a gain/bearing stage.
// Depends on c2bd_pkg, c2bd_req_if, c2bd_rsp_if, c2bd_prep, c2bd_cell, c2bd_post.
//
//   port    dir  carries                                         accepted when
//   req_i   in   target_x, target_y, current_x, current_y (s16)  valid && ready
//   rsp_o   out  distance (u17, input units), bearing (u15, 1/64 deg) valid && ready
//
// Throughput: one request per cycle while rsp_o accepts. Registered stages in order:
// front stage, one cell per micro-rotation, multiply stage, round/wrap stage.
// Reset clears only the per-stage valid bits; payload registers are not reset.
// Each stage has its own valid bit and takes new data whenever it is empty
// or its successor moves, so bubbles close up while rsp_o is stalled.
`timescale 1ns / 1ps

module cartesian_to_bearing_distance_core import c2bd_pkg::*; #(
  parameter int unsigned ITERATIONS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  c2bd_req_if.sink          req_i,
  c2bd_rsp_if.source        rsp_o
);

  // micro-rotations beyond the table length add nothing
  localparam int unsigned NumCells = (ITERATIONS < ATAN_LEN) ? ITERATIONS : ATAN_LEN;

  c2bd_pt_t  pt;
  // stage k feeds cell k; stage NumCells feeds the post stage
  c2bd_vec_t stage_vec   [NumCells+1];
  logic      stage_valid [NumCells+1];
  logic      stage_ready [NumCells+1];

  assign pt.target_x  = req_i.target_x;
  assign pt.target_y  = req_i.target_y;
  assign pt.current_x = req_i.current_x;
  assign pt.current_y = req_i.current_y;

  // Difference vector, half-plane fold, on-axis cases.
  c2bd_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_i.valid),
    .ready_o (req_i.ready),
    .pt_i    (pt),
    .valid_o (stage_valid[0]),
    .ready_i (stage_ready[0]),
    .vec_o   (stage_vec[0])
  );

  // Row of micro-rotation cells; cell k shifts by k and adds or subtracts atan(2^-k).
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    c2bd_cell #(
      .SHIFT (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stage_valid[k]),
      .ready_o (stage_ready[k]),
      .vec_i   (stage_vec[k]),
      .valid_o (stage_valid[k+1]),
      .ready_i (stage_ready[k+1]),
      .vec_o   (stage_vec[k+1])
    );
  end

  // Gain correction, rounding, saturation and bearing wrap; drives rsp_o.
  c2bd_post u_post (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (stage_valid[NumCells]),
    .ready_o    (stage_ready[NumCells]),
    .vec_i      (stage_vec[NumCells]),
    .valid_o    (rsp_o.valid),
    .ready_i    (rsp_o.ready),
    .distance_o (rsp_o.distance),
    .bearing_o  (rsp_o.bearing)
  );

endmodule

// ===== rtl/core/c2bd_prep.sv =====
// c2bd_prep: front stage. Forms the difference vector, folds the southern half
// of the compass, and resolves the on-axis cases. Depends on c2bd_pkg.
`timescale 1ns / 1ps

module c2bd_prep import c2bd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  c2bd_pt_t  pt_i,
  output logic      valid_o,
  input  logic      ready_i,
  output c2bd_vec_t vec_o
);

  logic signed [DIFF_W-1:0] dx, dy;
  logic [DIFF_W-1:0]        dx_abs, dy_abs;
  logic signed [UV_W-1:0]   u0, v0;
  c2bd_vec_t                vec_d, vec_q;
  logic                     valid_q;

  always_comb begin
    dx = {pt_i.target_x[COORD_W-1], pt_i.target_x} - {pt_i.current_x[COORD_W-1], pt_i.current_x};
    dy = {pt_i.target_y[COORD_W-1], pt_i.target_y} - {pt_i.current_y[COORD_W-1], pt_i.current_y};
    dx_abs = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    dy_abs = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    u0 = {{(UV_W-DIFF_W-GUARD_SHIFT){dy[DIFF_W-1]}}, dy, {GUARD_SHIFT{1'b0}}};
    v0 = {{(UV_W-DIFF_W-GUARD_SHIFT){dx[DIFF_W-1]}}, dx, {GUARD_SHIFT{1'b0}}};

    // southern half (dy < 0): negate and start from 180 degrees
    if (dy[DIFF_W-1]) begin
      vec_d.u = -u0;
      vec_d.v = -v0;
      vec_d.z = Z_180;
    end else begin
      vec_d.u = u0;
      vec_d.v = v0;
      vec_d.z = '0;
    end

    vec_d.sp      = (dx == '0) || (dy == '0);
    vec_d.sp_dist = '0;
    vec_d.sp_bear = BEAR_90;
    if (dx == '0 && dy == '0) begin
      vec_d.sp_dist = '0;
      vec_d.sp_bear = BEAR_90;
    end else if (dx == '0) begin
      vec_d.sp_dist = DIST_W'(dy_abs);
      vec_d.sp_bear = dy[DIFF_W-1] ? BEAR_180 : BEAR_0;
    end else if (dy == '0) begin
      vec_d.sp_dist = DIST_W'(dx_abs);
      vec_d.sp_bear = dx[DIFF_W-1] ? BEAR_270 : BEAR_90;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      vec_q <= vec_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule

// ===== rtl/core/c2bd_cell.sv =====
// c2bd_cell: one CORDIC vectoring micro-rotation with its own register.
// Depends on c2bd_pkg.
`timescale 1ns / 1ps

module c2bd_cell import c2bd_pkg::*; #(
  parameter int unsigned SHIFT = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  c2bd_vec_t vec_i,
  output logic      valid_o,
  input  logic      ready_i,
  output c2bd_vec_t vec_o
);

  localparam logic signed [Z_W-1:0] AngStep = atan_lookup(ATAN_IDX_W'(SHIFT));

  logic signed [UV_W-1:0] us, vs;
  c2bd_vec_t              vec_d, vec_q;
  logic                   valid_q;

  always_comb begin
    us    = vec_i.u >>> SHIFT;  // floor shift
    vs    = vec_i.v >>> SHIFT;
    vec_d = vec_i;
    if (!vec_i.v[UV_W-1]) begin
      vec_d.u = vec_i.u + vs;
      vec_d.v = vec_i.v - us;
      vec_d.z = vec_i.z + AngStep;
    end else begin
      vec_d.u = vec_i.u - vs;
      vec_d.v = vec_i.v + us;
      vec_d.z = vec_i.z - AngStep;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      vec_q <= vec_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule

// ===== rtl/core/c2bd_post.sv =====
// c2bd_post: gain correction (multiply, then round and saturate) and
// bearing wrap, two registered stages. Depends on c2bd_pkg.
`timescale 1ns / 1ps

module c2bd_post import c2bd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  c2bd_vec_t         vec_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [DIST_W-1:0] distance_o,
  output logic [BEAR_W-1:0] bearing_o
);

  localparam int unsigned RND_W = PROD_W + 1;

  // stage 1: multiply and angle offset
  logic [UV_W-2:0]          u_pos;
  logic signed [T_W-1:0]    t;
  logic [BQ_W-1:0]          bq_d, bq_q;
  logic [PROD_W-1:0]        prod_d, prod_q;
  logic                     sp_q;
  logic [DIST_W-1:0]        sp_dist_q;
  logic [BEAR_W-1:0]        sp_bear_q;
  logic                     valid1_q, ready1;

  // stage 2: round, saturate, wrap
  logic [RND_W-1:0]         rnd;
  logic [RND_W-41:0]        dist_full;
  logic [BQ_W-1:0]          bear_wrap;
  logic [DIST_W-1:0]        dist_d, dist_q;
  logic [BEAR_W-1:0]        bear_d, bear_q;
  logic                     valid2_q, ready2;

  always_comb begin
    u_pos  = vec_i.u[UV_W-1] ? '0 : vec_i.u[UV_W-2:0];
    prod_d = PROD_W'(u_pos) * PROD_W'(KINV_Q32);
    t      = {vec_i.z[Z_W-1], vec_i.z} + Z_OFFSET;
    bq_d   = t[T_W-1] ? '0 : t[T_W-1:12];
  end

  always_comb begin
    rnd       = {1'b0, prod_q} + (RND_W'(1) << 39);
    dist_full = rnd[RND_W-1:40];
    bear_wrap = (bq_q >= BEAR_FULL) ? (bq_q - BEAR_FULL) : bq_q;
    if (sp_q) begin
      dist_d = sp_dist_q;
      bear_d = sp_bear_q;
    end else begin
      dist_d = (|dist_full[RND_W-41:DIST_W]) ? '1 : dist_full[DIST_W-1:0];
      bear_d = bear_wrap[BEAR_W-1:0];
    end
  end

  assign ready2  = !valid2_q || ready_i;
  assign ready1  = !valid1_q || ready2;
  assign ready_o = ready1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      if (ready1) begin
        valid1_q <= valid_i;
      end
      if (ready2) begin
        valid2_q <= valid1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready1) begin
      prod_q    <= prod_d;
      bq_q      <= bq_d;
      sp_q      <= vec_i.sp;
      sp_dist_q <= vec_i.sp_dist;
      sp_bear_q <= vec_i.sp_bear;
    end
    if (valid1_q && ready2) begin
      dist_q <= dist_d;
      bear_q <= bear_d;
    end
  end

  assign valid_o    = valid2_q;
  assign distance_o = dist_q;
  assign bearing_o  = bear_q;

endmodule
